// ===== rtl/core/owbm_pkg.sv =====
// ----------------------------------------------------------------------------
// owbm_pkg
// types and constants shared by the single-wire bus master
// ----------------------------------------------------------------------------
package owbm_pkg;

  localparam int unsigned CfgWidth    = 10;
  localparam int unsigned CfgIdxWidth = 3;

  // register reset values
  localparam logic [CfgWidth-1:0] RstLowDefault   = 10'd600;
  localparam logic [CfgWidth-1:0] PresWinDefault  = 10'd100;
  localparam logic [CfgWidth-1:0] RstRecDefault   = 10'd250;
  localparam logic [CfgWidth-1:0] SlotStDefault   = 10'd2;
  localparam logic [CfgWidth-1:0] SampDlyDefault  = 10'd2;
  localparam logic [CfgWidth-1:0] SlotHoldDefault = 10'd100;
  localparam logic [CfgWidth-1:0] WrRecDefault    = 10'd2;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_RESET_LOW  = 3'd0,
    CFG_PRES_WIN   = 3'd1,
    CFG_RESET_REC  = 3'd2,
    CFG_SLOT_START = 3'd3,
    CFG_SAMPLE_DLY = 3'd4,
    CFG_SLOT_HOLD  = 3'd5,
    CFG_WRITE_REC  = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RST_LOW   = 4'd1,
    PH_PRES      = 4'd2,
    PH_REC       = 4'd3,
    PH_SLOT_LOW  = 4'd4,
    PH_WR_HOLD   = 4'd5,
    PH_WR_REC    = 4'd6,
    PH_RD_WAIT   = 4'd7,
    PH_RD_SAMPLE = 4'd8,
    PH_RD_HOLD   = 4'd9
  } phase_e;

  typedef struct packed {
    logic [CfgWidth-1:0] reset_low_time;
    logic [CfgWidth-1:0] presence_window;
    logic [CfgWidth-1:0] reset_recovery_time;
    logic [CfgWidth-1:0] slot_start_time;
    logic [CfgWidth-1:0] sample_delay;
    logic [CfgWidth-1:0] slot_hold_time;
    logic [CfgWidth-1:0] write_recovery_time;
  } cfg_t;

  typedef struct packed {
    logic       pull_low;
    logic       busy_res;
    logic       done_res;
    logic       presence_seen;
    logic [7:0] read_data;
  } res_t;

endpackage

// ===== rtl/core/owbm_ifs.sv =====
// ----------------------------------------------------------------------------
// owbm interfaces
// valid/ready channels for requests, results and register writes
// ----------------------------------------------------------------------------
interface owbm_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] write_data;
  logic       line_level;

  modport source (output valid, output req_type, output write_data,
                  output line_level, input ready);
  modport sink (input valid, input req_type, input write_data,
                input line_level, output ready);
endinterface

interface owbm_res_if;
  logic       valid;
  logic       ready;
  logic       pull_low;
  logic       busy_res;
  logic       done_res;
  logic       presence_seen;
  logic [7:0] read_data;

  modport source (output valid, output pull_low, output busy_res, output done_res,
                  output presence_seen, output read_data, input ready);
  modport sink (input valid, input pull_low, input busy_res, input done_res,
                input presence_seen, input read_data, output ready);
endinterface

interface owbm_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [9:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/one_wire_bus_master.sv =====
// ----------------------------------------------------------------------------
// one_wire_bus_master
// single-wire bus master: reset/presence, byte write and byte read sequencing
// ----------------------------------------------------------------------------
// result: registered, valid in the cycle after its tick beat
// throughput: one tick beat per cycle while the result side keeps up
// a stalled result beat holds off new ticks; a draining one lets the next in
// reset: sequencer to idle, flags and read byte cleared, timing registers to
// their defaults; no clearing pass, the block takes beats right after reset
module one_wire_bus_master
  import owbm_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  owbm_cfg_if.sink   cfg_i,
  owbm_req_if.sink   in_i,
  owbm_res_if.source out_o
);

  cfg_t cfg;
  res_t res;
  logic tick_fire;

  // register writes are always taken
  assign cfg_i.ready = 1'b1;

  owbm_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid),
    .wr_idx_i  (cfg_i.index),
    .wr_data_i (cfg_i.data),
    .cfg_o     (cfg)
  );

  // a tick beat is taken whenever the result register is free or draining
  logic out_valid_q;
  res_t out_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign tick_fire  = in_i.valid && in_i.ready;

  // sequencer advances by one step on each accepted tick
  owbm_seq #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (tick_fire),
    .req_type_i   (in_i.req_type),
    .write_data_i (in_i.write_data),
    .line_level_i (in_i.line_level),
    .cfg_i        (cfg),
    .res_o        (res)
  );

  // result register: valid bit reset, payload loaded with each tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_fire) begin
      out_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.pull_low      = out_q.pull_low;
  assign out_o.busy_res      = out_q.busy_res;
  assign out_o.done_res      = out_q.done_res;
  assign out_o.presence_seen = out_q.presence_seen;
  assign out_o.read_data     = out_q.read_data;

`ifndef NO_ASSERTIONS
  // every accepted tick yields a result beat in the next cycle
  a_tick_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_fire |=> out_valid_q)
    else $error("accepted tick produced no result beat");

  // a waiting result is never overwritten by a new tick
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while result stalled");

  // the finishing tick of an operation is still a busy tick
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.done_res) |-> out_q.busy_res)
    else $error("done reported on an idle tick");
`endif

endmodule

// ===== rtl/core/owbm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// owbm_cfg_regs
// timing register file, written one register per beat
// ----------------------------------------------------------------------------
module owbm_cfg_regs
  import owbm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   wr_en_i,
  input  logic [CfgIdxWidth-1:0] wr_idx_i,
  input  logic [CfgWidth-1:0]    wr_data_i,
  output cfg_t                   cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_idx_i)
        CFG_RESET_LOW:  cfg_d.reset_low_time      = wr_data_i;
        CFG_PRES_WIN:   cfg_d.presence_window     = wr_data_i;
        CFG_RESET_REC:  cfg_d.reset_recovery_time = wr_data_i;
        CFG_SLOT_START: cfg_d.slot_start_time     = wr_data_i;
        CFG_SAMPLE_DLY: cfg_d.sample_delay        = wr_data_i;
        CFG_SLOT_HOLD:  cfg_d.slot_hold_time      = wr_data_i;
        CFG_WRITE_REC:  cfg_d.write_recovery_time = wr_data_i;
        default:        cfg_d = cfg_q; // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_time      <= RstLowDefault;
      cfg_q.presence_window     <= PresWinDefault;
      cfg_q.reset_recovery_time <= RstRecDefault;
      cfg_q.slot_start_time     <= SlotStDefault;
      cfg_q.sample_delay        <= SampDlyDefault;
      cfg_q.slot_hold_time      <= SlotHoldDefault;
      cfg_q.write_recovery_time <= WrRecDefault;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/owbm_seq.sv =====
// ----------------------------------------------------------------------------
// owbm_seq
// bus sequencer: one step per accepted tick beat
// ----------------------------------------------------------------------------
module owbm_seq
  import owbm_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [1:0] req_type_i,
  input  logic [7:0] write_data_i,
  input  logic       line_level_i,
  input  cfg_t       cfg_i,
  output res_t       res_o
);

  typedef logic [TIMER_WIDTH-1:0] tmr_t;

  phase_e     phase_q, phase_d;
  op_e        op_q, op_d;
  tmr_t       timer_q, timer_d;
  logic [2:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic       pres_q, pres_d;
  logic [7:0] last_q, last_d;

  // durations taken modulo the timer width
  tmr_t t_rst_low, t_pres, t_rst_rec, t_slot, t_samp, t_hold, t_wr_rec;

  function automatic tmr_t min_one(input tmr_t t);
    tmr_t r;
    r = (t == '0) ? tmr_t'(1) : t;
    return r;
  endfunction

  always_comb begin
    t_rst_low = min_one(TIMER_WIDTH'(cfg_i.reset_low_time));
    t_pres    = min_one(TIMER_WIDTH'(cfg_i.presence_window));
    t_slot    = min_one(TIMER_WIDTH'(cfg_i.slot_start_time));
    t_hold    = min_one(TIMER_WIDTH'(cfg_i.slot_hold_time));
    t_rst_rec = TIMER_WIDTH'(cfg_i.reset_recovery_time);
    t_samp    = TIMER_WIDTH'(cfg_i.sample_delay);
    t_wr_rec  = TIMER_WIDTH'(cfg_i.write_recovery_time);
  end

  // next state
  logic pull, busy, done, go_rec, go_next, go_finish, zero;
  tmr_t dec;

  always_comb begin
    phase_d   = phase_q;
    op_d      = op_q;
    timer_d   = timer_q;
    bit_d     = bit_q;
    shift_d   = shift_q;
    pres_d    = pres_q;
    last_d    = last_q;
    pull      = 1'b0;
    done      = 1'b0;
    go_rec    = 1'b0;
    go_next   = 1'b0;
    go_finish = 1'b0;

    // command start, only from idle
    if (phase_d == PH_IDLE && op_e'(req_type_i) != OP_NONE) begin
      op_d  = op_e'(req_type_i);
      bit_d = 3'd0;
      if (op_e'(req_type_i) == OP_RESET) begin
        phase_d = PH_RST_LOW;
        timer_d = t_rst_low;
      end else begin
        shift_d = (op_e'(req_type_i) == OP_WRITE) ? write_data_i : 8'h00;
        phase_d = PH_SLOT_LOW;
        timer_d = t_slot;
      end
    end
    busy = (phase_d != PH_IDLE);
    dec  = timer_d - tmr_t'(1);
    zero = (dec == '0);

    case (phase_d)
      PH_IDLE: begin
      end
      PH_RST_LOW: begin
        pull    = 1'b1;
        timer_d = dec;
        if (zero) begin
          phase_d = PH_PRES;
          timer_d = t_pres;
        end
      end
      PH_PRES: begin
        if (!line_level_i) begin
          pres_d = 1'b1;
          go_rec = 1'b1;
        end else begin
          timer_d = dec;
          if (zero) begin
            pres_d = 1'b0;
            go_rec = 1'b1;
          end
        end
      end
      PH_REC: begin
        timer_d   = dec;
        go_finish = zero;
      end
      PH_SLOT_LOW: begin
        pull    = 1'b1;
        timer_d = dec;
        if (zero) begin
          if (op_d == OP_WRITE) begin
            phase_d = PH_WR_HOLD;
            timer_d = t_hold;
          end else begin
            phase_d = (t_samp == '0) ? PH_RD_SAMPLE : PH_RD_WAIT;
            timer_d = t_samp;
          end
        end
      end
      PH_WR_HOLD: begin
        pull    = ~shift_d[0];
        timer_d = dec;
        if (zero) begin
          shift_d = {1'b0, shift_d[7:1]};
          phase_d = PH_WR_REC;
          timer_d = t_wr_rec;
          go_next = (t_wr_rec == '0);
        end
      end
      PH_WR_REC: begin
        timer_d = dec;
        go_next = zero;
      end
      PH_RD_WAIT: begin
        timer_d = dec;
        if (zero) begin
          phase_d = PH_RD_SAMPLE;
        end
      end
      PH_RD_SAMPLE: begin
        shift_d = {line_level_i, shift_d[7:1]};
        phase_d = PH_RD_HOLD;
        timer_d = t_hold;
      end
      PH_RD_HOLD: begin
        timer_d = dec;
        go_next = zero;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    if (go_rec) begin
      phase_d   = PH_REC;
      timer_d   = t_rst_rec;
      go_finish = (t_rst_rec == '0);
    end
    if (go_next) begin
      if (bit_d == 3'd7) begin
        go_finish = 1'b1;
      end else begin
        bit_d   = bit_d + 3'd1;
        phase_d = PH_SLOT_LOW;
        timer_d = t_slot;
      end
    end
    if (go_finish) begin
      if (op_d == OP_READ) begin
        last_d = shift_d;
      end
      phase_d = PH_IDLE;
      timer_d = '0;
      done    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      op_q    <= OP_NONE;
      timer_q <= '0;
      bit_q   <= 3'd0;
      shift_q <= 8'h00;
      pres_q  <= 1'b0;
      last_q  <= 8'h00;
    end else if (step_i) begin
      phase_q <= phase_d;
      op_q    <= op_d;
      timer_q <= timer_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      pres_q  <= pres_d;
      last_q  <= last_d;
    end
  end

  always_comb begin
    res_o.pull_low      = pull;
    res_o.busy_res      = busy;
    res_o.done_res      = done;
    res_o.presence_seen = pres_d;
    res_o.read_data     = last_d;
  end

endmodule
